/* sv/bmaf_pkg.sv */
// bmaf_pkg: widths, scale factors and divider constants for the battery
// monitor ADC filter. No dependencies; imported by battery_monitor_adc_filter.

package bmaf_pkg;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int ADC_W    = 12;
  localparam int PERIOD_W = 16;
  localparam int VOLT_W   = 22;
  localparam int CURR_W   = 26;
  localparam int TEMP_W   = 17;
  localparam int SEQ_W    = 8;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-3:0] REG_PERIOD_IDX = 1'd0;
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 16'd20;

  // Small divide by 5 for 12-bit values: floor(n * 6554 / 2^15)
  localparam int DIV5_SHIFT   = 15;
  localparam int DIV5_MAGIC_W = 13;
  localparam int Q5_W         = 10;
  localparam logic [DIV5_MAGIC_W-1:0] DIV5_MAGIC = 13'(((1 << DIV5_SHIFT) + 4) / 5);

  // Voltage: adc * 19 * 3.3 / 4096 in Q.16 = adc * 5016 / 5 = adc * 1003 + adc / 5
  localparam logic [9:0] VOLT_GAIN_INT = 10'(5016 / 5);
  localparam logic [VOLT_W-1:0] VOLT_SAMPLE_MAX = 22'd4108104;

  // Current: adc * 600 * 1.1 / 4096 in Q.16 = adc * 10560 (exact)
  localparam logic [13:0] CURR_GAIN = 14'd10560;
  localparam logic [CURR_W-1:0] CURR_SAMPLE_MAX = 26'd43243200;

  // Temperature: trunc((1750 - adc) / 5) degrees C, then to centikelvin at 25 C offset
  localparam int TEMPQ_W = 10;
  localparam logic signed [ADC_W:0]    TEMP_ZERO_ADC  = 13'sd1750;
  localparam logic signed [TEMP_W-1:0] TEMP_STEP_CK   = 17'sd100;
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET_CK = 17'sd29815;
  localparam logic signed [TEMP_W-1:0] TEMP_CK_MIN    = -17'sd17085;
  localparam logic signed [TEMP_W-1:0] TEMP_CK_MAX    = 17'sd64815;

  // Averaging windows
  localparam int VOLT_WINDOW = 5;
  localparam int CURR_WINDOW = 50;

  // Reciprocal for floor(n / W), n < 2^N_W: magic = ceil(2^(N_W+log2W) / W)
  localparam int VOLT_LOG   = $clog2(VOLT_WINDOW);
  localparam int VOLT_N_W   = VOLT_W + 1;
  localparam int VOLT_SHIFT = VOLT_N_W + VOLT_LOG;
  typedef logic [VOLT_N_W:0] volt_magic_t;
  localparam volt_magic_t VOLT_MAGIC =
    volt_magic_t'(((64'd1 << VOLT_SHIFT) + 64'(VOLT_WINDOW) - 64'd1) / 64'(VOLT_WINDOW));

  localparam int CURR_LOG   = $clog2(CURR_WINDOW);
  localparam int CURR_N_W   = CURR_W + 1;
  localparam int CURR_SHIFT = CURR_N_W + CURR_LOG;
  typedef logic [CURR_N_W:0] curr_magic_t;
  localparam curr_magic_t CURR_MAGIC =
    curr_magic_t'(((64'd1 << CURR_SHIFT) + 64'(CURR_WINDOW) - 64'd1) / 64'(CURR_WINDOW));

endpackage

/* sv/battery_monitor_adc_filter.sv */
// battery_monitor_adc_filter: sample conversion, running averages and update pacing.
// Depends on bmaf_pkg for widths and constants.

// A request carries a millisecond tick and three raw ADC readings. When the tick has
// reached the last update time plus period_ms (32-bit wrapping sum), one result is
// published: voltage and current in Q.16 after running averages over 5 and 50 samples,
// temperature in centikelvin, and an 8-bit transfer counter. Other requests produce no
// result and leave the state alone. The block takes one request per clock while no due
// request waits on a stalled output: the input register holds the scaled samples, and the
// update stage (due compare plus one reciprocal multiply per average, closing the state loop
// without a further register) writes the output register. A result passes from the input
// register to the output register after its request is accepted; a stalled output holds and
// the input side keeps moving while requests are not due.
module battery_monitor_adc_filter
  import bmaf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [TIME_W-1:0]          time_ms,
  input  logic [ADC_W-1:0]           vin_adc,
  input  logic [ADC_W-1:0]           temp_adc,
  input  logic [ADC_W-1:0]           curr_adc,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [VOLT_W-1:0]          voltage_out,
  output logic [CURR_W-1:0]          current_out,
  output logic signed [TEMP_W-1:0]   temp_centikelvin,
  output logic [SEQ_W-1:0]           seq_id,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  // Configuration
  logic [PERIOD_W-1:0] period_ms;
  logic                cfg_write;

  // Input register
  logic                    s1_valid;
  logic [TIME_W-1:0]       s1_time;
  logic [VOLT_W-1:0]       s1_vsample;
  logic [CURR_W-1:0]       s1_csample;
  logic [TEMPQ_W-1:0]      s1_temp_q;

  // Filter state
  logic [TIME_W-1:0]       last_update_ms;
  logic [VOLT_W-1:0]       voltage_avg;
  logic [CURR_W-1:0]       current_avg;
  logic [SEQ_W-1:0]        seq_count;

  // Sample conversion
  logic [ADC_W+DIV5_MAGIC_W-1:0] vin_div5_prod;
  logic [VOLT_W-1:0]             vsample;
  logic [CURR_W-1:0]             csample;
  logic signed [ADC_W:0]         temp_diff;
  logic [ADC_W:0]                temp_neg;
  logic [ADC_W-1:0]              temp_mag;
  logic [ADC_W+DIV5_MAGIC_W-1:0] temp_div5_prod;
  logic [Q5_W-1:0]               temp_q_mag;
  logic [TEMPQ_W-1:0]            temp_q;

  // Update stage
  logic [TIME_W-1:0]             due_ms;
  logic                          s1_due;
  logic                          out_free;
  logic                          s1_advance;
  logic                          publish;
  logic                          in_take;

  logic [VOLT_N_W-1:0]           v_diff;
  logic [VOLT_N_W-1:0]           v_num;
  logic [VOLT_SHIFT+VOLT_N_W-1:0] v_prod;
  logic [VOLT_N_W-1:0]           v_q;
  logic [VOLT_W-1:0]             voltage_avg_next;

  logic [CURR_N_W-1:0]           c_diff;
  logic [CURR_N_W-1:0]           c_num;
  logic [CURR_SHIFT+CURR_N_W-1:0] c_prod;
  logic [CURR_N_W-1:0]           c_q;
  logic [CURR_W-1:0]             current_avg_next;

  logic signed [TEMP_W-1:0]      temp_ck;

  // APB: always ready, single period register at word 0
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[APB_ADDR_W-1:2] == REG_PERIOD_IDX);

  always_comb begin
    if (paddr[APB_ADDR_W-1:2] == REG_PERIOD_IDX) begin
      prdata = APB_DATA_W'(period_ms);
    end else begin
      prdata = '0;
    end
  end

  // Voltage sample: adc * 1003 + floor(adc / 5)
  assign vin_div5_prod = (ADC_W+DIV5_MAGIC_W)'(vin_adc) * (ADC_W+DIV5_MAGIC_W)'(DIV5_MAGIC);
  assign vsample = VOLT_W'(vin_adc) * VOLT_W'(VOLT_GAIN_INT)
                 + VOLT_W'(vin_div5_prod[DIV5_SHIFT +: Q5_W]);

  // Current sample is an exact constant scale
  assign csample = CURR_W'(curr_adc) * CURR_W'(CURR_GAIN);

  // Temperature quotient, truncated toward zero through the magnitude
  assign temp_diff      = TEMP_ZERO_ADC - $signed({1'b0, temp_adc});
  assign temp_neg       = 13'd0 - temp_diff;
  assign temp_mag       = temp_diff[ADC_W] ? temp_neg[ADC_W-1:0] : temp_diff[ADC_W-1:0];
  assign temp_div5_prod = (ADC_W+DIV5_MAGIC_W)'(temp_mag) * (ADC_W+DIV5_MAGIC_W)'(DIV5_MAGIC);
  assign temp_q_mag     = temp_div5_prod[DIV5_SHIFT +: Q5_W];
  assign temp_q         = temp_diff[ADC_W] ? (TEMPQ_W'(0) - TEMPQ_W'(temp_q_mag))
                                           : TEMPQ_W'(temp_q_mag);

  // Pacing and flow control
  assign due_ms     = last_update_ms + TIME_W'(period_ms);
  assign s1_due     = !(s1_time < due_ms);
  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && (!s1_due || out_free);
  assign publish    = s1_advance && s1_due;
  assign in_ready   = !s1_valid || s1_advance;
  assign in_take    = in_valid && in_ready;

  // Voltage average: avg + floor((x - avg) / W)
  always_comb begin
    v_diff = VOLT_N_W'(s1_vsample) - VOLT_N_W'(voltage_avg);
    if (v_diff[VOLT_N_W-1]) begin
      v_num = (VOLT_N_W'(0) - v_diff) + VOLT_N_W'(VOLT_WINDOW - 1);
    end else begin
      v_num = v_diff;
    end
    v_prod = (VOLT_SHIFT+VOLT_N_W)'(v_num) * (VOLT_SHIFT+VOLT_N_W)'(VOLT_MAGIC);
    v_q    = v_prod[VOLT_SHIFT +: VOLT_N_W];
    if (v_diff[VOLT_N_W-1]) begin
      voltage_avg_next = voltage_avg - v_q[VOLT_W-1:0];
    end else begin
      voltage_avg_next = voltage_avg + v_q[VOLT_W-1:0];
    end
  end

  // Current average, same form
  always_comb begin
    c_diff = CURR_N_W'(s1_csample) - CURR_N_W'(current_avg);
    if (c_diff[CURR_N_W-1]) begin
      c_num = (CURR_N_W'(0) - c_diff) + CURR_N_W'(CURR_WINDOW - 1);
    end else begin
      c_num = c_diff;
    end
    c_prod = (CURR_SHIFT+CURR_N_W)'(c_num) * (CURR_SHIFT+CURR_N_W)'(CURR_MAGIC);
    c_q    = c_prod[CURR_SHIFT +: CURR_N_W];
    if (c_diff[CURR_N_W-1]) begin
      current_avg_next = current_avg - c_q[CURR_W-1:0];
    end else begin
      current_avg_next = current_avg + c_q[CURR_W-1:0];
    end
  end

  // Centikelvin from the stored quotient
  assign temp_ck = TEMP_W'($signed(s1_temp_q)) * TEMP_STEP_CK + TEMP_OFFSET_CK;

  // Control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms      <= PERIOD_RESET;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      last_update_ms <= '0;
      voltage_avg    <= '0;
      current_avg    <= '0;
      seq_count      <= '0;
    end else begin
      if (cfg_write) begin
        period_ms <= pwdata[PERIOD_W-1:0];
      end
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (publish) begin
        out_valid      <= 1'b1;
        last_update_ms <= s1_time;
        voltage_avg    <= voltage_avg_next;
        current_avg    <= current_avg_next;
        seq_count      <= seq_count + SEQ_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_time    <= time_ms;
      s1_vsample <= vsample;
      s1_csample <= csample;
      s1_temp_q  <= temp_q;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (publish) begin
      voltage_out      <= voltage_avg_next;
      current_out      <= current_avg_next;
      temp_centikelvin <= temp_ck;
      seq_id           <= seq_count;
    end
  end

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !publish)
    else $error("result overwritten while stalled");

  // Counter steps by one per update
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    publish |=> (seq_count == $past(seq_count) + SEQ_W'(1)))
    else $error("transfer counter did not step");

  // No update leaves the pacing time alone
  a_time_hold: assert property (@(posedge clk) disable iff (rst)
    !publish |=> $stable(last_update_ms))
    else $error("update time changed without an update");

  // Averages never leave the sample range
  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    (voltage_avg <= VOLT_SAMPLE_MAX) && (current_avg <= CURR_SAMPLE_MAX))
    else $error("running average out of range");

  // Published temperature stays in its range
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((temp_centikelvin >= TEMP_CK_MIN) && (temp_centikelvin <= TEMP_CK_MAX)))
    else $error("temperature out of range");

endmodule
